// File: design/clps_pkg.sv
// Package with the types, codes and constants shared by the character LCD sequencer files.
package clps_pkg;

    // Default values of the top-level parameters.
    localparam int BUFFER_DEPTH_DEF   = 256;
    localparam int POWER_ON_TICKS_DEF = 16;

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int COL_W     = 6;
    localparam int ROW_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int PHASE_W   = 3;
    localparam int POWER_W   = 5;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 1;

    // Request codes.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    // Power-on sequence phases.
    localparam logic [PHASE_W-1:0] PH_POWER = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FUNC  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DISP  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CLEAR = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ENTRY = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd5;

    // Running operations.
    localparam logic [OP_W-1:0] OP_IDLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_MOVE  = 2'd3;

    // Row codes accepted by a cursor move.
    localparam logic [ROW_W-1:0] ROW_FIRST  = 2'd1;
    localparam logic [ROW_W-1:0] ROW_SECOND = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_LINES      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_LARGE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ON     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_INCREMENT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_SHIFT  = 3'd6;

    // Instruction opcodes and prefixes.
    localparam logic [3:0]        FUNC_SET_PREFIX = 4'b0011;
    localparam logic [4:0]        DISP_CTL_PREFIX = 5'b00001;
    localparam logic [5:0]        ENTRY_PREFIX    = 6'b000001;
    localparam logic [CHAR_W-1:0] CLEAR_INSTR     = 8'h01;
    localparam logic [1:0]        DDRAM_ROW1_HI   = 2'b10;
    localparam logic [1:0]        DDRAM_ROW2_HI   = 2'b11;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } clps_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                lcd_rs;
        logic                lcd_rw;
        logic                lcd_en;
        logic [CHAR_W-1:0]   lcd_data;
        logic                init_done;
        logic                busy_res;
    } clps_rsp_t;

    typedef struct packed {
        logic two_lines;
        logic font_large;
        logic display_on;
        logic cursor_on;
        logic blink_on;
        logic addr_increment;
        logic display_shift;
    } clps_cfg_t;

endpackage

// File: design/clps_if.sv
// Valid/ready channel interfaces for the request and result beats.
interface clps_req_if;
    logic                          valid;
    logic                          ready;
    logic [clps_pkg::CMD_W-1:0]    command;
    logic [clps_pkg::CHAR_W-1:0]   char_code;
    logic                          last_char;
    logic [clps_pkg::COL_W-1:0]    column;
    logic [clps_pkg::ROW_W-1:0]    row;

    modport source (output valid, command, char_code, last_char, column, row, input ready);
    modport sink   (input valid, command, char_code, last_char, column, row, output ready);
endinterface

interface clps_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [clps_pkg::STATUS_W-1:0]   status;
    logic                            lcd_rs;
    logic                            lcd_rw;
    logic                            lcd_en;
    logic [clps_pkg::CHAR_W-1:0]     lcd_data;
    logic                            init_done;
    logic                            busy_res;

    modport source (output valid, status, lcd_rs, lcd_rw, lcd_en, lcd_data, init_done,
                    busy_res, input ready);
    modport sink   (input valid, status, lcd_rs, lcd_rw, lcd_en, lcd_data, init_done,
                    busy_res, output ready);
endinterface

// File: design/clps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module clps_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/clps_seq.sv
// Sequencer state and next-state logic: power-on sequence, requests and strobe generation.
module clps_seq #(
    parameter int BUFFER_DEPTH   = clps_pkg::BUFFER_DEPTH_DEF,
    parameter int POWER_ON_TICKS = clps_pkg::POWER_ON_TICKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  clps_pkg::clps_req_t req,
    input  clps_pkg::clps_cfg_t cfg,
    output clps_pkg::clps_rsp_t rsp
);

    localparam int IW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = clps_pkg::CHAR_W;
    localparam int PW = clps_pkg::POWER_W;

    logic [clps_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [PW-1:0]                 power_reg, power_next;
    logic [clps_pkg::OP_W-1:0]     op_reg, op_next;
    logic                          en_reg, en_next;
    logic                          rs_reg, rs_next;
    logic [CW-1:0]                 data_reg, data_next;
    logic [IW-1:0]                 lidx_reg, lidx_next;
    logic [IW-1:0]                 wlen_reg, wlen_next;
    logic [IW-1:0]                 widx_reg, widx_next;
    logic [clps_pkg::COL_W-1:0]    tcol_reg, tcol_next;
    logic [clps_pkg::ROW_W-1:0]    trow_reg, trow_next;
    logic                          byp_valid_reg;
    logic [CW-1:0]                 byp_data_reg;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [AW-1:0]                 mem_raddr;
    logic [CW-1:0]                 mem_q;
    logic [CW-1:0]                 buf_data;
    logic [CW-1:0]                 init_cmd;
    logic [CW-1:0]                 move_addr;
    logic                          strb_req;
    logic                          strb_rs;
    logic [CW-1:0]                 strb_data;
    logic [clps_pkg::STATUS_W-1:0] status;

    // The character buffer is read at the index the next write beat will use.
    assign mem_waddr = lidx_reg[AW-1:0];
    assign mem_raddr = widx_next[AW-1:0];
    assign buf_data  = byp_valid_reg ? byp_data_reg : mem_q;

    clps_ram #(
        .WIDTH  (CW),
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (AW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (req.char_code),
        .rd_addr (mem_raddr),
        .rd_data (mem_q)
    );

    always_comb
    begin
        case (phase_reg)
            clps_pkg::PH_FUNC:
                init_cmd = {clps_pkg::FUNC_SET_PREFIX, cfg.two_lines, cfg.font_large, 2'b00};
            clps_pkg::PH_DISP:
                init_cmd = {clps_pkg::DISP_CTL_PREFIX, cfg.display_on, cfg.cursor_on,
                            cfg.blink_on};
            clps_pkg::PH_CLEAR:
                init_cmd = clps_pkg::CLEAR_INSTR;
            default:
                init_cmd = {clps_pkg::ENTRY_PREFIX, cfg.addr_increment, cfg.display_shift};
        endcase
    end

    // Row two starts at DDRAM address 0x40; the column never reaches it, so the add is a set bit.
    assign move_addr = (trow_reg == clps_pkg::ROW_SECOND) ? {clps_pkg::DDRAM_ROW2_HI, tcol_reg}
                                                          : {clps_pkg::DDRAM_ROW1_HI, tcol_reg};

    always_comb
    begin
        phase_next = phase_reg;
        power_next = power_reg;
        op_next    = op_reg;
        en_next    = en_reg;
        rs_next    = rs_reg;
        data_next  = data_reg;
        lidx_next  = lidx_reg;
        wlen_next  = wlen_reg;
        widx_next  = widx_reg;
        tcol_next  = tcol_reg;
        trow_next  = trow_reg;
        mem_we     = 1'b0;
        strb_req   = 1'b0;
        strb_rs    = 1'b0;
        strb_data  = init_cmd;
        status     = clps_pkg::ST_OK;

        if (fire)
        begin
            if (req.command == clps_pkg::CMD_TICK)
            begin
                if (phase_reg < clps_pkg::PH_DONE)
                begin
                    if (phase_reg == clps_pkg::PH_POWER)
                    begin
                        if (power_reg < PW'(POWER_ON_TICKS))
                        begin
                            power_next = power_reg + 1'b1;
                        end
                        else
                        begin
                            power_next = '0;
                            phase_next = clps_pkg::PH_FUNC;
                        end
                    end
                    else
                    begin
                        strb_req = 1'b1;
                    end
                end
                else
                begin
                    case (op_reg)
                        clps_pkg::OP_WRITE:
                        begin
                            if (widx_reg < wlen_reg && widx_reg < IW'(BUFFER_DEPTH))
                            begin
                                strb_req  = 1'b1;
                                strb_rs   = 1'b1;
                                strb_data = buf_data;
                            end
                            else
                            begin
                                op_next   = clps_pkg::OP_IDLE;
                                widx_next = '0;
                            end
                        end
                        clps_pkg::OP_CLEAR:
                        begin
                            strb_req  = 1'b1;
                            strb_data = clps_pkg::CLEAR_INSTR;
                        end
                        clps_pkg::OP_MOVE:
                        begin
                            strb_req  = 1'b1;
                            strb_data = move_addr;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else if (op_reg != clps_pkg::OP_IDLE)
            begin
                status = clps_pkg::ST_BUSY;
            end
            else
            begin
                case (req.command)
                    clps_pkg::CMD_LOAD:
                    begin
                        if (lidx_reg < IW'(BUFFER_DEPTH))
                        begin
                            mem_we    = 1'b1;
                            lidx_next = lidx_reg + 1'b1;
                        end
                        else
                        begin
                            status = clps_pkg::ST_BAD;
                        end
                        if (req.last_char)
                        begin
                            wlen_next = lidx_next;
                            widx_next = '0;
                            lidx_next = '0;
                            op_next   = clps_pkg::OP_WRITE;
                        end
                    end
                    clps_pkg::CMD_CLEAR:
                    begin
                        op_next = clps_pkg::OP_CLEAR;
                    end
                    clps_pkg::CMD_MOVE:
                    begin
                        if (req.row == clps_pkg::ROW_FIRST || req.row == clps_pkg::ROW_SECOND)
                        begin
                            tcol_next = req.column;
                            trow_next = req.row;
                            op_next   = clps_pkg::OP_MOVE;
                        end
                        else
                        begin
                            status = clps_pkg::ST_BAD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // A strobe beat either raises EN with RS and data set up, or drops EN and
        // completes the instruction that was on the bus.
        if (strb_req)
        begin
            if (en_reg)
            begin
                en_next = 1'b0;
                if (phase_reg < clps_pkg::PH_DONE)
                begin
                    phase_next = (phase_reg >= clps_pkg::PH_ENTRY) ? clps_pkg::PH_DONE
                                                                   : phase_reg + 1'b1;
                end
                else if (op_reg == clps_pkg::OP_WRITE)
                begin
                    widx_next = widx_reg + 1'b1;
                end
                else
                begin
                    op_next = clps_pkg::OP_IDLE;
                end
            end
            else
            begin
                rs_next   = strb_rs;
                data_next = strb_data;
                en_next   = 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp.status    = status;
        rsp.lcd_rs    = rs_next;
        rsp.lcd_rw    = 1'b0;
        rsp.lcd_en    = en_next;
        rsp.lcd_data  = data_next;
        rsp.init_done = (phase_next >= clps_pkg::PH_DONE);
        rsp.busy_res  = (phase_next < clps_pkg::PH_DONE) || (op_next != clps_pkg::OP_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= clps_pkg::PH_POWER;
            power_reg     <= '0;
            op_reg        <= clps_pkg::OP_IDLE;
            en_reg        <= 1'b0;
            rs_reg        <= 1'b0;
            data_reg      <= '0;
            lidx_reg      <= '0;
            wlen_reg      <= '0;
            widx_reg      <= '0;
            tcol_reg      <= '0;
            trow_reg      <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            power_reg     <= power_next;
            op_reg        <= op_next;
            en_reg        <= en_next;
            rs_reg        <= rs_next;
            data_reg      <= data_next;
            lidx_reg      <= lidx_next;
            wlen_reg      <= wlen_next;
            widx_reg      <= widx_next;
            tcol_reg      <= tcol_next;
            trow_reg      <= trow_next;
            // A load that lands on the entry being read is forwarded past the RAM.
            byp_valid_reg <= mem_we && (mem_waddr == mem_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byp_data_reg <= req.char_code;
        end
    end

endmodule

// File: design/char_lcd_parallel_sequencer_top.sv
// Top level of the character LCD parallel sequencer: channels, configuration and pipeline registers.
//
// Usage: every request beat on the req channel is either a tick (command 0), which
// advances the LCD pin sequence by one step, or a request: load a character into the
// buffer (the beat flagged last_char starts writing the buffer as data), clear the
// display, or move the cursor to row 1 or 2. Each request beat yields exactly one
// result beat on the rsp channel with a status code and the LCD pin levels (RS, RW,
// EN, D0-D7) after that step, plus init_done and busy_res flags.
// Pipeline: a request register feeds the sequencer logic, whose answer lands in a
// result register. A beat accepted into the request register is processed by the
// sequencer and its answer is held in the result register until rsp takes it. One
// beat is accepted every cycle while rsp is ready.
// Reset: clears all sequencer state and loads the configuration defaults. The block
// then counts POWER_ON_TICKS+1 ticks before it runs the power-on instruction sequence.
// The character buffer is not cleared. Configuration is written through cfg_we, cfg_addr
// and cfg_wdata; the user must do so while no beat is in flight; the block does not enforce it.
// Stall: when rsp is not ready the result register holds its beat; the request
// register still takes one more beat, after which req.ready drops until rsp drains.
module char_lcd_parallel_sequencer_top #(
    parameter int BUFFER_DEPTH   = clps_pkg::BUFFER_DEPTH_DEF,
    parameter int POWER_ON_TICKS = clps_pkg::POWER_ON_TICKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    clps_req_if.sink                       req,
    clps_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [clps_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [clps_pkg::CFG_DAT_W-1:0] cfg_wdata
);

    clps_pkg::clps_cfg_t cfg_reg;
    logic                s1_valid_reg;
    clps_pkg::clps_req_t s1_req_reg;
    logic                out_valid_reg;
    clps_pkg::clps_rsp_t out_rsp_reg;
    clps_pkg::clps_rsp_t seq_rsp;
    logic                s1_fire;
    logic                in_fire;

    // The sequencer step runs whenever the result register is free or being emptied.
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign in_fire   = req.valid && req.ready;

    // Configuration registers, each a single function bit of an init instruction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.two_lines      <= 1'b1;
            cfg_reg.font_large     <= 1'b0;
            cfg_reg.display_on     <= 1'b1;
            cfg_reg.cursor_on      <= 1'b0;
            cfg_reg.blink_on       <= 1'b0;
            cfg_reg.addr_increment <= 1'b1;
            cfg_reg.display_shift  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                clps_pkg::CFG_TWO_LINES:      cfg_reg.two_lines      <= cfg_wdata[0];
                clps_pkg::CFG_FONT_LARGE:     cfg_reg.font_large     <= cfg_wdata[0];
                clps_pkg::CFG_DISPLAY_ON:     cfg_reg.display_on     <= cfg_wdata[0];
                clps_pkg::CFG_CURSOR_ON:      cfg_reg.cursor_on      <= cfg_wdata[0];
                clps_pkg::CFG_BLINK_ON:       cfg_reg.blink_on       <= cfg_wdata[0];
                clps_pkg::CFG_ADDR_INCREMENT: cfg_reg.addr_increment <= cfg_wdata[0];
                clps_pkg::CFG_DISPLAY_SHIFT:  cfg_reg.display_shift  <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Request register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Request payload needs no reset; it is only looked at under the valid flag.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg.command   <= req.command;
            s1_req_reg.char_code <= req.char_code;
            s1_req_reg.last_char <= req.last_char;
            s1_req_reg.column    <= req.column;
            s1_req_reg.row       <= req.row;
        end
    end

    clps_seq #(
        .BUFFER_DEPTH   (BUFFER_DEPTH),
        .POWER_ON_TICKS (POWER_ON_TICKS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .req   (s1_req_reg),
        .cfg   (cfg_reg),
        .rsp   (seq_rsp)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_rsp_reg <= seq_rsp;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_rsp_reg.status;
    assign rsp.lcd_rs    = out_rsp_reg.lcd_rs;
    assign rsp.lcd_rw    = out_rsp_reg.lcd_rw;
    assign rsp.lcd_en    = out_rsp_reg.lcd_en;
    assign rsp.lcd_data  = out_rsp_reg.lcd_data;
    assign rsp.init_done = out_rsp_reg.init_done;
    assign rsp.busy_res  = out_rsp_reg.busy_res;

endmodule

// File: test/char_lcd_parallel_sequencer_top_test.sv
// Self-checking testbench for the character LCD parallel sequencer top level.
`timescale 1ns / 1ps

module char_lcd_parallel_sequencer_top_test;
    import clps_pkg::*;

    localparam int BUF_DEPTH = BUFFER_DEPTH_DEF;
    localparam int PWR_TICKS = POWER_ON_TICKS_DEF;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // While the power-on wait runs, the pins sit at zero and the block reports busy,
    // so the answer to any beat in that window can be written down directly.
    localparam clps_rsp_t WAIT_OK   = '{ST_OK,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1};
    localparam clps_rsp_t WAIT_BUSY = '{ST_BUSY, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1};
    localparam clps_rsp_t WAIT_BAD  = '{ST_BAD,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1};

    typedef struct {
        clps_req_t beat;
        int        reps;
        bit        typed;
        clps_rsp_t want;
        bit        reprogram;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    clps_req_if req_if ();
    clps_rsp_if rsp_if ();

    char_lcd_parallel_sequencer_top #(
        .BUFFER_DEPTH   (BUF_DEPTH),
        .POWER_ON_TICKS (PWR_TICKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Our own copy of the sequencer. It starts in the reset state, which is entered
    // exactly once at the start of the run.
    clps_cfg_t   cfg_now   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    logic [2:0]  phase     = PH_POWER;
    int          power_cnt = 0;
    logic [1:0]  op_now    = OP_IDLE;
    logic        en_lvl    = 1'b0;
    logic        rs_lvl    = 1'b0;
    logic [7:0]  pin_data  = 8'h00;
    logic [7:0]  char_mem [0:BUF_DEPTH-1];
    int          fill_idx  = 0;
    int          str_len   = 0;
    int          str_pos   = 0;
    logic [5:0]  move_col  = '0;
    logic [1:0]  move_row  = '0;

    // Pin answers still owed by the block, oldest first.
    clps_rsp_t   answers_due [$];
    int          fail_count = 0;

    // Sender burst and receiver stall bookkeeping.
    int          burst_left  = 0;
    int          stall_count = 0;
    int          stall_mode  = 0;
    logic [15:0] stall_mask  = 16'hFFFF;

    // One EN strobe step: the first call raises EN with RS and data set up, the
    // second drops EN and reports that the instruction is complete.
    function automatic bit pulse_en(input logic rs, input logic [7:0] d);
        if (en_lvl)
        begin
            en_lvl = 1'b0;
            return 1'b1;
        end
        rs_lvl   = rs;
        pin_data = d;
        en_lvl   = 1'b1;
        return 1'b0;
    endfunction

    // Applies one accepted beat to the copy of the sequencer and returns the answer
    // the block must give for it.
    function automatic clps_rsp_t lcd_advance(input clps_req_t r);
        clps_rsp_t   out;
        logic [1:0]  status;
        logic [7:0]  instr;
        status = ST_OK;
        if (r.command == CMD_TICK)
        begin
            if (phase == PH_POWER)
            begin
                if (power_cnt < PWR_TICKS)
                    power_cnt++;
                else
                begin
                    power_cnt = 0;
                    phase     = PH_FUNC;
                end
            end
            else if (phase != PH_DONE)
            begin
                case (phase)
                    PH_FUNC:  instr = {FUNC_SET_PREFIX, cfg_now.two_lines, cfg_now.font_large,
                                       2'b00};
                    PH_DISP:  instr = {DISP_CTL_PREFIX, cfg_now.display_on, cfg_now.cursor_on,
                                       cfg_now.blink_on};
                    PH_CLEAR: instr = CLEAR_INSTR;
                    default:  instr = {ENTRY_PREFIX, cfg_now.addr_increment,
                                       cfg_now.display_shift};
                endcase
                if (pulse_en(1'b0, instr))
                    phase = phase + 3'd1;
            end
            else if (op_now == OP_WRITE)
            begin
                if (str_pos < str_len)
                begin
                    if (pulse_en(1'b1, char_mem[BUF_AW'(str_pos)]))
                        str_pos++;
                end
                else
                begin
                    // The write ends one tick after its last EN fall.
                    op_now  = OP_IDLE;
                    str_pos = 0;
                end
            end
            else if (op_now == OP_CLEAR)
            begin
                if (pulse_en(1'b0, CLEAR_INSTR))
                    op_now = OP_IDLE;
            end
            else if (op_now == OP_MOVE)
            begin
                instr = (move_row == ROW_SECOND) ? {DDRAM_ROW2_HI, move_col}
                                                 : {DDRAM_ROW1_HI, move_col};
                if (pulse_en(1'b0, instr))
                    op_now = OP_IDLE;
            end
        end
        else if (op_now != OP_IDLE)
            status = ST_BUSY;
        else if (r.command == CMD_LOAD)
        begin
            if (fill_idx < BUF_DEPTH)
            begin
                char_mem[BUF_AW'(fill_idx)] = r.char_code;
                fill_idx++;
            end
            else
                status = ST_BAD;
            // A last character starts the write even when it was itself dropped.
            if (r.last_char)
            begin
                str_len  = fill_idx;
                str_pos  = 0;
                fill_idx = 0;
                op_now   = OP_WRITE;
            end
        end
        else if (r.command == CMD_CLEAR)
            op_now = OP_CLEAR;
        else if (r.row == ROW_FIRST || r.row == ROW_SECOND)
        begin
            move_col = r.column;
            move_row = r.row;
            op_now   = OP_MOVE;
        end
        else
            status = ST_BAD;

        out.status    = status;
        out.lcd_rs    = rs_lvl;
        out.lcd_rw    = 1'b0;
        out.lcd_en    = en_lvl;
        out.lcd_data  = pin_data;
        out.init_done = (phase == PH_DONE);
        out.busy_res  = (phase != PH_DONE) || (op_now != OP_IDLE);
        return out;
    endfunction

    function automatic clps_req_t beat_of(input logic [1:0] cmd, input logic [7:0] ch,
                                          input logic last, input logic [5:0] col,
                                          input logic [1:0] rw);
        clps_req_t b;
        b.command   = cmd;
        b.char_code = ch;
        b.last_char = last;
        b.column    = col;
        b.row       = rw;
        return b;
    endfunction

    function automatic plan_row_t step_row(input clps_req_t b, input int reps, input bit typed,
                                           input clps_rsp_t want, input bit reprogram);
        plan_row_t p;
        p.beat      = b;
        p.reps      = reps;
        p.typed     = typed;
        p.want      = want;
        p.reprogram = reprogram;
        return p;
    endfunction

    // Random beat shaped by the current state: while an operation runs, mostly ticks
    // so that it completes, with the odd request that must be turned away as busy.
    // While idle, a mix of ticks, strings, clears and cursor moves.
    function automatic clps_req_t random_beat();
        clps_req_t b;
        int        pick;
        b.char_code = 8'($urandom);
        b.last_char = ($urandom_range(0, 5) == 0);
        b.column    = 6'($urandom);
        b.row       = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                    : (($urandom_range(0, 1) != 0) ? ROW_SECOND : ROW_FIRST);
        pick = $urandom_range(0, 99);
        if (op_now != OP_IDLE)
            b.command = (pick < 85) ? CMD_TICK : 2'($urandom_range(1, 3));
        else if (pick < 45)
            b.command = CMD_TICK;
        else if (pick < 75)
            b.command = CMD_LOAD;
        else if (pick < 85)
            b.command = CMD_CLEAR;
        else
            b.command = CMD_MOVE;
        return b;
    endfunction

    function automatic void match_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // Offers one beat and waits for it to be taken. The sender runs in bursts: at
    // the end of each burst it may drop valid before the next beat, or not at all.
    task automatic send_beat(input clps_req_t b, input bit typed, input clps_rsp_t want);
        clps_rsp_t model_out;
        int        gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        req_if.valid     <= 1'b1;
        req_if.command   <= b.command;
        req_if.char_code <= b.char_code;
        req_if.last_char <= b.last_char;
        req_if.column    <= b.column;
        req_if.row       <= b.row;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        model_out = lcd_advance(b);
        answers_due.push_back(typed ? want : model_out);
    endtask

    task automatic send_tick();
        send_beat(beat_of(CMD_TICK, 8'($urandom), 1'($urandom), 6'($urandom), 2'($urandom)),
                  1'b0, '0);
    endtask

    // Stops offering beats and waits until every owed answer has come back.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    // Writes one register; back-to-back calls keep the write enable high.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    task automatic apply_settings(input clps_cfg_t s);
        put_reg(CFG_TWO_LINES,      s.two_lines);
        put_reg(CFG_FONT_LARGE,     s.font_large);
        put_reg(CFG_DISPLAY_ON,     s.display_on);
        put_reg(CFG_CURSOR_ON,      s.cursor_on);
        put_reg(CFG_BLINK_ON,       s.blink_on);
        put_reg(CFG_ADDR_INCREMENT, s.addr_increment);
        put_reg(CFG_DISPLAY_SHIFT,  s.display_shift);
        cfg_we  <= 1'b0;
        cfg_now  = s;
    endtask

    // Receiver: picks a new stall style whenever its stall counter runs out. Style 0 never
    // stalls, style 1 follows a random 16-bit mask, style 2 takes a beat only
    // now and then.
    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode  <= $urandom_range(0, 2);
            stall_mask  <= 16'($urandom) | 16'h0001;
            stall_count <= $urandom_range(32, 256);
        end
        else
            stall_count <= stall_count - 1;
        case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= stall_mask[stall_count[3:0]];
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Every result beat taken is checked field by field against the oldest answer owed.
    always @(posedge clk)
    begin
        clps_rsp_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: result beat with no answer owed, status %0h", $time,
                         rsp_if.status);
                fail_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                match_field("status",    8'(want.status),    8'(rsp_if.status));
                match_field("lcd_rs",    8'(want.lcd_rs),    8'(rsp_if.lcd_rs));
                match_field("lcd_rw",    8'(want.lcd_rw),    8'(rsp_if.lcd_rw));
                match_field("lcd_en",    8'(want.lcd_en),    8'(rsp_if.lcd_en));
                match_field("lcd_data",  want.lcd_data,      rsp_if.lcd_data);
                match_field("init_done", 8'(want.init_done), 8'(rsp_if.init_done));
                match_field("busy_res",  8'(want.busy_res),  8'(rsp_if.busy_res));
            end
        end
    end

    initial
    begin
        plan_row_t plan [$];

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_addr         = '0;
        cfg_wdata        = '0;
        req_if.valid     = 1'b0;
        req_if.command   = CMD_TICK;
        req_if.char_code = '0;
        req_if.last_char = 1'b0;
        req_if.column    = '0;
        req_if.row       = '0;

        // Directed part. The first rows fall in the power-on wait, where requests are
        // still accepted and queued behind init; their answers are typed in.
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), 1, 1'b1,
                                WAIT_OK, 1'b0));
        // Moves to a row other than 1 or 2 are rejected.
        plan.push_back(step_row(beat_of(CMD_MOVE, 8'h00, 1'b0, 6'd63, 2'd0), 1, 1'b1,
                                WAIT_BAD, 1'b0));
        plan.push_back(step_row(beat_of(CMD_MOVE, 8'h00, 1'b0, 6'd0, 2'd3), 1, 1'b1,
                                WAIT_BAD, 1'b0));
        // A two-character string loaded during init; it waits for init to finish.
        plan.push_back(step_row(beat_of(CMD_LOAD, 8'hFF, 1'b0, 6'd0, 2'd0), 1, 1'b1,
                                WAIT_OK, 1'b0));
        plan.push_back(step_row(beat_of(CMD_LOAD, 8'h00, 1'b1, 6'd0, 2'd0), 1, 1'b1,
                                WAIT_OK, 1'b0));
        // With the write pending, every further request is answered busy.
        plan.push_back(step_row(beat_of(CMD_CLEAR, 8'h00, 1'b0, 6'd0, 2'd0), 1, 1'b1,
                                WAIT_BUSY, 1'b0));
        plan.push_back(step_row(beat_of(CMD_MOVE, 8'h00, 1'b0, 6'd5, ROW_FIRST), 1, 1'b1,
                                WAIT_BUSY, 1'b0));
        plan.push_back(step_row(beat_of(CMD_LOAD, 8'h55, 1'b1, 6'd0, 2'd0), 1, 1'b1,
                                WAIT_BUSY, 1'b0));
        // The rest of the power-on wait plus the function set, sent with all-ones settings.
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), PWR_TICKS + 2,
                                1'b0, '0, 1'b0));
        // The remaining init instructions go out with all-zero settings, then the
        // pending string is written and the sequencer falls idle; one idle tick more.
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), 12, 1'b0, '0,
                                1'b1));
        // Cursor moves at both column extremes on both rows, and a clear.
        plan.push_back(step_row(beat_of(CMD_MOVE, 8'h00, 1'b0, 6'd0, ROW_FIRST), 1, 1'b0, '0,
                                1'b0));
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), 2, 1'b0, '0, 1'b0));
        plan.push_back(step_row(beat_of(CMD_MOVE, 8'h00, 1'b0, 6'd63, ROW_SECOND), 1, 1'b0,
                                '0, 1'b0));
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), 2, 1'b0, '0, 1'b0));
        plan.push_back(step_row(beat_of(CMD_MOVE, 8'h00, 1'b0, 6'd63, ROW_FIRST), 1, 1'b0,
                                '0, 1'b0));
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), 2, 1'b0, '0, 1'b0));
        plan.push_back(step_row(beat_of(CMD_MOVE, 8'h00, 1'b0, 6'd0, ROW_SECOND), 1, 1'b0,
                                '0, 1'b0));
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), 2, 1'b0, '0, 1'b0));
        plan.push_back(step_row(beat_of(CMD_CLEAR, 8'h00, 1'b0, 6'd0, 2'd0), 1, 1'b0, '0,
                                1'b0));
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), 2, 1'b0, '0, 1'b0));
        // A one-character string, then a string with an idle tick between its loads.
        plan.push_back(step_row(beat_of(CMD_LOAD, 8'hA5, 1'b1, 6'd0, 2'd0), 1, 1'b0, '0,
                                1'b0));
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), 3, 1'b0, '0, 1'b0));
        plan.push_back(step_row(beat_of(CMD_LOAD, 8'h5A, 1'b0, 6'd0, 2'd0), 1, 1'b0, '0,
                                1'b0));
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), 1, 1'b0, '0, 1'b0));
        plan.push_back(step_row(beat_of(CMD_LOAD, 8'h80, 1'b1, 6'd0, 2'd0), 1, 1'b0, '0,
                                1'b0));
        plan.push_back(step_row(beat_of(CMD_TICK, 8'h00, 1'b0, 6'd0, 2'd0), 5, 1'b0, '0, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start from the high extreme of every register so the function set shows it.
        apply_settings('1);

        foreach (plan[i])
        begin
            if (plan[i].reprogram)
            begin
                drain();
                apply_settings('0);
            end
            repeat (plan[i].reps)
                send_beat(plan[i].beat, plan[i].typed, plan[i].want);
        end

        // Buffer full: load every entry, then two more characters that are dropped with
        // a bad-request answer; the second is marked last and still starts the write
        // of the full buffer, which is then ticked through to the end.
        while (op_now != OP_IDLE)
            send_tick();
        repeat (BUF_DEPTH)
            send_beat(beat_of(CMD_LOAD, 8'($urandom), 1'b0, 6'($urandom), 2'($urandom)),
                      1'b0, '0);
        send_beat(beat_of(CMD_LOAD, 8'($urandom), 1'b0, 6'($urandom), 2'($urandom)),
                  1'b0, '0);
        send_beat(beat_of(CMD_LOAD, 8'($urandom), 1'b1, 6'($urandom), 2'($urandom)),
                  1'b0, '0);
        while (op_now != OP_IDLE)
            send_tick();

        // Random part in three phases, with fresh register values between them.
        repeat (3)
        begin
            drain();
            apply_settings(clps_cfg_t'($urandom));
            repeat (320)
                send_beat(random_beat(), 1'b0, '0);
        end

        // Let the last answers come back, then keep watching for any stray beat.
        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
